>>> sv/h2s_pkg.sv
// shared types, constants and lookup functions for the hid report to set-1 converter
package h2s_pkg;

  localparam int unsigned ModCount = 6;
  localparam int unsigned RomSize  = 88;

  localparam logic [7:0] PrefixExt = 8'hE0;
  localparam logic [7:0] BreakBit  = 8'h80;

  localparam logic [2:0] LastMod = 3'(ModCount - 1);

  typedef enum logic [2:0] {
    StIdle,
    StMods,
    StPress,
    StRelease,
    StFlush
  } h2s_state_e;

  // request to the translate unit
  typedef struct packed {
    logic       is_mod;
    logic       mod_edge;
    logic       brk;
    logic [2:0] mod_idx;
  } h2s_req_t;

  // answer from the translate unit
  typedef struct packed {
    logic       hit;
    logic       pfx;
    logic [7:0] code;
  } h2s_rsp_t;

  localparam logic [7:0] CodeRom [0:RomSize-1] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
    8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
    8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
    8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
    8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
    8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
    8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
    8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h00, 8'h46,
    8'h00, 8'h52, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51, 8'h4D,
    8'h4B, 8'h50, 8'h48, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] rom_code(input logic [7:0] key);
    logic [7:0] res;
    res = 8'h00;
    if (key < 8'(RomSize)) begin
      res = CodeRom[key[6:0]];
    end
    return res;
  endfunction

  function automatic logic key_ext(input logic [7:0] key);
    return (key == 8'h4A) || ((key >= 8'h4D) && (key <= 8'h52));
  endfunction

  // bit position of each modifier in scan order
  function automatic logic [2:0] mod_pos(input logic [2:0] idx);
    logic [2:0] res;
    unique case (idx)
      3'd0:    res = 3'd0;
      3'd1:    res = 3'd1;
      3'd2:    res = 3'd2;
      3'd3:    res = 3'd4;
      3'd4:    res = 3'd5;
      3'd5:    res = 3'd6;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] mod_make(input logic [2:0] idx);
    logic [7:0] res;
    unique case (idx)
      3'd0:    res = 8'h1D;
      3'd1:    res = 8'h2A;
      3'd2:    res = 8'h38;
      3'd3:    res = 8'h1D;
      3'd4:    res = 8'h36;
      3'd5:    res = 8'h38;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  // right ctrl and right alt only
  function automatic logic mod_ext(input logic [2:0] idx);
    return (idx == 3'd3) || (idx == 3'd5);
  endfunction

endpackage

>>> sv/h2s_xlate.sv
// shared translate unit: membership compare, code rom lookup and prefix decision
module h2s_xlate import h2s_pkg::*; #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  h2s_req_t   req_i,
  input  logic [7:0] key_i,
  input  logic [7:0] set_i [KEY_SLOTS],
  output h2s_rsp_t   rsp_o
);

  logic       member;
  logic [7:0] code;

  always_comb begin
    member = 1'b0;
    for (int j = 0; j < int'(KEY_SLOTS); j++) begin
      if (set_i[j] == key_i) begin
        member = 1'b1;
      end
    end
  end

  assign code = rom_code(key_i);

  always_comb begin
    if (req_i.is_mod) begin
      rsp_o.hit  = req_i.mod_edge;
      rsp_o.pfx  = mod_ext(req_i.mod_idx);
      rsp_o.code = mod_make(req_i.mod_idx) | (req_i.brk ? BreakBit : 8'h00);
    end else begin
      rsp_o.hit  = (key_i != 8'h00) && !member && (code != 8'h00);
      rsp_o.pfx  = key_ext(key_i);
      rsp_o.code = code | (req_i.brk ? BreakBit : 8'h00);
    end
  end

endmodule

>>> sv/hid_report_to_set1_scancodes.sv
// top level: boot-keyboard report to set-1 scancode byte stream converter
//
// input channel s_axis: one boot-keyboard report per item. tuser flags a full
// report; an item with tuser low is taken and dropped without touching the
// stored report. output channel m_axis: one scancode byte per item, tlast
// marks the final byte caused by a report. a report equal to the stored one
// gives no bytes at all.
//
// a report is walked by a small sequencer over six modifier steps, then
// KEY_SLOTS press steps, then KEY_SLOTS release steps; each step uses the one
// shared translate unit. a step that sends an e0 prefix stays on for its code
// byte. s_axis_tready_o is high only in the idle state. bytes pass through a
// one-deep hold register so the last one can be marked, then an output
// register.
//
// reset clears the stored modifiers and keys to zero and empties the output.
// when the receiver stalls, the sequencer stops on the step that has a byte
// to place and resumes when the output register frees up; nothing is lost.
module hid_report_to_set1_scancodes import h2s_pkg::*; #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // modifier_bits [7:0], key_slot_0 [15:8] .. key_slot_5 [55:48]
  input  logic [55:0] s_axis_tdata_i,
  // report_complete [0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // scancode [7:0]
  output logic [7:0]  m_axis_tdata_o,
  // last_of_run
  output logic        m_axis_tlast_o
);

  localparam int unsigned SlotW    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam logic [2:0]  LastSlot = 3'(KEY_SLOTS - 1);

  h2s_state_e state_q, state_d;

  logic [2:0] idx_q, idx_d;
  logic       pfx_done_q, pfx_done_d;

  // stored report and the report being worked on
  logic [7:0] prev_mods_q;
  logic [7:0] prev_keys_q [KEY_SLOTS];
  logic [7:0] cur_mods_q;
  logic [7:0] cur_keys_q  [KEY_SLOTS];

  // hold register and output register
  logic       pend_vld_q, pend_vld_d;
  logic [7:0] pend_data_q, pend_data_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_last_q, out_last_d;

  logic       accept;
  logic       take;
  logic       scanning;
  logic       out_free;
  logic       byte_vld;
  logic [7:0] byte_val;
  logic       advance;
  logic       step_next;
  logic       last_step;
  logic       commit;

  logic [SlotW-1:0] slot;
  logic [2:0]       mpos;
  h2s_req_t         req;
  h2s_rsp_t         rsp;
  logic [7:0]       key;
  logic [7:0]       set  [KEY_SLOTS];

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign take            = accept && s_axis_tuser_i;
  assign scanning        = (state_q == StMods) || (state_q == StPress) ||
                           (state_q == StRelease);
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign slot            = idx_q[SlotW-1:0];
  assign mpos            = mod_pos(idx_q);

  // step request to the shared unit
  always_comb begin
    req.is_mod   = (state_q == StMods);
    req.mod_idx  = idx_q;
    req.mod_edge = cur_mods_q[mpos] != prev_mods_q[mpos];
    req.brk      = (state_q == StMods) ? !cur_mods_q[mpos] : (state_q == StRelease);
    if (state_q == StRelease) begin
      key = prev_keys_q[slot];
      set = cur_keys_q;
    end else begin
      key = cur_keys_q[slot];
      set = prev_keys_q;
    end
  end

  h2s_xlate #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_xlate (
    .req_i(req),
    .key_i(key),
    .set_i(set),
    .rsp_o(rsp)
  );

  assign byte_vld  = scanning && rsp.hit;
  assign byte_val  = (rsp.pfx && !pfx_done_q) ? PrefixExt : rsp.code;
  // a byte can be placed when the hold register is empty or can move out
  assign advance   = !byte_vld || !pend_vld_q || out_free;
  // the step is finished unless it just sent its prefix
  assign step_next = scanning && advance && !(byte_vld && rsp.pfx && !pfx_done_q);
  assign last_step = (state_q == StMods) ? (idx_q == LastMod) : (idx_q == LastSlot);
  assign commit    = (state_q == StRelease) && step_next && last_step;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          state_d = StMods;
        end
      end
      StMods: begin
        if (step_next && last_step) begin
          state_d = StPress;
        end
      end
      StPress: begin
        if (step_next && last_step) begin
          state_d = StRelease;
        end
      end
      StRelease: begin
        if (step_next && last_step) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (!pend_vld_q || out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // sequencer counters and byte path
  always_comb begin
    idx_d       = idx_q;
    pfx_done_d  = pfx_done_q;
    pend_vld_d  = pend_vld_q;
    pend_data_d = pend_data_q;
    out_vld_d   = out_vld_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    if (take) begin
      idx_d      = 3'd0;
      pfx_done_d = 1'b0;
    end

    if (scanning && advance) begin
      if (byte_vld) begin
        if (pend_vld_q) begin
          out_vld_d  = 1'b1;
          out_data_d = pend_data_q;
          out_last_d = 1'b0;
        end
        pend_vld_d  = 1'b1;
        pend_data_d = byte_val;
        pfx_done_d  = !step_next;
      end
      if (step_next) begin
        idx_d = last_step ? 3'd0 : idx_q + 3'd1;
      end
    end

    // last byte of the run goes out marked
    if ((state_q == StFlush) && pend_vld_q && out_free) begin
      out_vld_d  = 1'b1;
      out_data_d = pend_data_q;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      idx_q      <= 3'd0;
      pfx_done_q <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      prev_mods_q <= 8'h00;
      for (int i = 0; i < int'(KEY_SLOTS); i++) begin
        prev_keys_q[i] <= 8'h00;
      end
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      pfx_done_q <= pfx_done_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (commit) begin
        prev_mods_q <= cur_mods_q;
        prev_keys_q <= cur_keys_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_data_q <= pend_data_d;
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
    if (take) begin
      cur_mods_q <= s_axis_tdata_i[7:0];
      for (int i = 0; i < int'(KEY_SLOTS); i++) begin
        cur_keys_q[i] <= s_axis_tdata_i[8*i+8 +: 8];
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> sim/hid_report_to_set1_scancodes_tb.sv
// testbench for the boot-keyboard report to set-1 scancode converter

localparam logic [7:0] ExtPrefix = 8'hE0;
localparam logic [7:0] BreakFlag = 8'h80;
localparam int unsigned MapSize  = 88;

typedef struct packed {
  logic [7:0] code;
  logic       last;
} scan_byte_t;

// predicts the scancode run of each report and checks the output bytes against it
class scancode_board;
  scan_byte_t  expected_q[$];
  logic [7:0]  held_mods;
  logic [7:0]  held_keys [6];
  logic [7:0]  usage_map [MapSize];
  int unsigned edge_bit  [6];
  logic [7:0]  edge_make [6];
  bit          edge_ext  [6];
  int unsigned mismatches;

  function new();
    usage_map = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20,
      8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
      8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
      8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h02, 8'h03,
      8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
      8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A,
      8'h1B, 8'h2B, 8'h2B, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34,
      8'h35, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
      8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58, 8'h00, 8'h46,
      8'h00, 8'h52, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51, 8'h4D,
      8'h4B, 8'h50, 8'h48, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00
    };
    // lctrl, lshift, lalt, rctrl, rshift, ralt; the meta bits never emit
    edge_bit  = '{0, 1, 2, 4, 5, 6};
    edge_make = '{8'h1D, 8'h2A, 8'h38, 8'h1D, 8'h36, 8'h38};
    edge_ext  = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    held_mods = 8'h00;
    foreach (held_keys[i]) held_keys[i] = 8'h00;
    mismatches = 0;
  endfunction

  function void add_byte(logic [7:0] code);
    expected_q.push_back('{code: code, last: 1'b0});
  endfunction

  function void add_key(logic [7:0] key, logic brk);
    logic [7:0] code;
    if (key >= 8'(MapSize)) return;
    code = usage_map[key[6:0]];
    if (code == 8'h00) return;
    if (key == 8'h4A || (key >= 8'h4D && key <= 8'h52)) add_byte(ExtPrefix);
    add_byte(brk ? (code | BreakFlag) : code);
  endfunction

  function bit in_set(logic [7:0] slots [6], logic [7:0] key);
    foreach (slots[j]) if (slots[j] == key) return 1'b1;
    return 1'b0;
  endfunction

  function void note_report(bit complete, logic [7:0] mods, logic [5:0][7:0] keys);
    logic [7:0] now_keys [6];
    int unsigned start;
    if (!complete) return;
    start = expected_q.size();
    foreach (now_keys[i]) now_keys[i] = keys[i];
    for (int i = 0; i < 6; i++) begin
      if (mods[edge_bit[i]] != held_mods[edge_bit[i]]) begin
        if (edge_ext[i]) add_byte(ExtPrefix);
        add_byte(mods[edge_bit[i]] ? edge_make[i] : (edge_make[i] | BreakFlag));
      end
    end
    for (int i = 0; i < 6; i++)
      if (now_keys[i] != 8'h00 && !in_set(held_keys, now_keys[i])) add_key(now_keys[i], 1'b0);
    for (int i = 0; i < 6; i++)
      if (held_keys[i] != 8'h00 && !in_set(now_keys, held_keys[i])) add_key(held_keys[i], 1'b1);
    held_mods = mods;
    held_keys = now_keys;
    if (expected_q.size() > start) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  function void note_error(string what);
    mismatches++;
    if (mismatches <= 10) $display("scancode error: %s", what);
  endfunction

  function void check_byte(logic [7:0] code, logic last);
    scan_byte_t want;
    if (expected_q.size() == 0) begin
      note_error($sformatf("unexpected byte %02h last %0b", code, last));
      return;
    end
    want = expected_q.pop_front();
    if (want.code !== code || want.last !== last)
      note_error($sformatf("expected %02h last %0b, got %02h last %0b",
                           want.code, want.last, code, last));
  endfunction

  function int unsigned outstanding();
    return expected_q.size();
  endfunction
endclass

module hid_report_to_set1_scancodes_tb;

  localparam int unsigned ItemsPerPhase = 103;
  localparam int unsigned LongHold      = 300;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              s_valid   = 1'b0;
  logic              s_ready;
  logic [55:0]       s_data    = '0;
  logic              s_user    = 1'b0;
  logic              m_valid;
  logic              m_ready   = 1'b0;
  logic [7:0]        m_data;
  logic              m_last;

  scancode_board     board     = new();
  int unsigned       idle_pct  = 0;
  int unsigned       stall_pct = 0;
  int unsigned       hold_asked = 0;
  logic [7:0]        sent_mods = 8'h00;
  logic [5:0][7:0]   sent_keys = '0;

  hid_report_to_set1_scancodes DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_served != hold_asked) begin
        hold_left   = LongHold;
        hold_served = hold_served + 1;
      end
      if (hold_left != 0) begin
        m_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) board.check_byte(m_data, m_last);
  end

  task automatic send_report(bit complete, logic [7:0] mods, logic [5:0][7:0] keys);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {keys, mods};
    s_user  <= complete;
    do @(posedge clk); while (!s_ready);
    board.note_report(complete, mods, keys);
    if (complete) begin
      sent_mods = mods;
      sent_keys = keys;
    end
  endtask

  // mostly small edits of the last report, some repeats, short reports and noise
  task automatic next_report(output bit complete, output logic [7:0] mods,
                             output logic [5:0][7:0] keys);
    int unsigned pick;
    pick = $urandom_range(99);
    complete = 1'b1;
    mods     = sent_mods;
    keys     = sent_keys;
    if (pick < 8) begin
      complete = 1'b0;
      mods     = 8'($urandom());
      keys     = {$urandom(), 16'($urandom())};
    end else if (pick >= 13) begin
      case ($urandom_range(3))
        0:       mods = 8'($urandom());
        1, 2:    mods = sent_mods ^ (8'h01 << $urandom_range(7));
        default: mods = sent_mods;
      endcase
      for (int s = 0; s < 6; s++) begin
        pick = $urandom_range(99);
        if (pick < 35)      keys[s] = sent_keys[$urandom_range(5)];
        else if (pick < 60) keys[s] = 8'h00;
        else if (pick < 92) keys[s] = 8'($urandom_range(MapSize - 1));
        else                keys[s] = 8'($urandom());
      end
    end
  endtask

  initial begin
    bit              c;
    logic [7:0]      m;
    logic [5:0][7:0] k;
    int unsigned     waited;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every modifier on, metas included, then metas alone, then nothing
    send_report(1'b1, 8'hFF, '0);
    send_report(1'b1, 8'h88, '0);
    send_report(1'b1, 8'h00, '0);
    // extended keys pressed, then swapped under a full modifier change
    send_report(1'b1, 8'h00, {8'h51, 8'h50, 8'h4F, 8'h4E, 8'h4D, 8'h4A});
    send_report(1'b1, 8'h77, {8'h50, 8'h4F, 8'h4E, 8'h4D, 8'h4A, 8'h52});
    send_report(1'b1, 8'h00, '0);
    // one key in several slots, then the same report again
    send_report(1'b1, 8'h00, {8'h28, 8'h27, 8'h1D, 8'h04, 8'h04, 8'h04});
    send_report(1'b1, 8'h00, {8'h28, 8'h27, 8'h1D, 8'h04, 8'h04, 8'h04});
    // short report must leave the stored one alone
    send_report(1'b0, 8'hAA, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    // keys with zero map entries, then codes past the end of the map
    send_report(1'b1, 8'h00, {8'h57, 8'h46, 8'h03, 8'h02, 8'h01, 8'h00});
    send_report(1'b1, 8'h00, {8'hAA, 8'h59, 8'h7F, 8'hFF, 8'h80, 8'h58});
    send_report(1'b1, 8'h11, {8'h53, 8'h39, 8'h2C, 8'h2B, 8'h2A, 8'h29});
    send_report(1'b1, 8'h22, {8'h45, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00});
    send_report(1'b1, 8'h44, {8'h00, 8'h00, 8'h4C, 8'h4B, 8'h49, 8'h47});
    send_report(1'b1, 8'h00, {8'h53, 8'h4C, 8'h4B, 8'h54, 8'h56, 8'h55});
    send_report(1'b1, 8'hFF, {8'h52, 8'h4A, 8'h05, 8'h56, 8'h57, 8'h3A});
    send_report(1'b1, 8'h00, '0);

    // phases: no idling, sender idle, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 77; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      // long receiver hold-off while reports keep coming, so the input backs up
      if (phase == 0) hold_asked = hold_asked + 1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        next_report(c, m, k);
        send_report(c, m, k);
      end
    end
    s_valid <= 1'b0;

    waited = 0;
    while (board.outstanding() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);
    while (board.outstanding() != 0) begin
      board.note_error($sformatf("byte %02h never arrived", board.expected_q[0].code));
      void'(board.expected_q.pop_front());
    end

    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
